### hdl/sdsu_pkg.sv
// ----------------------------------------------------------------------------
// sdsu_pkg
// Shared widths, command codes, result kinds and the stage type for the sparse
// dot product and scatter update block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sdsu_pkg;

  // Field widths
  localparam int CMD_W = 2;
  localparam int IDX_W = 10;
  localparam int VAL_W = 32;
  localparam int RES_W = 48;
  localparam int ACC_W = 64;

  // Commands
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DOT    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd3;

  // Result kinds
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DOT  = 1'b1;

  // Beat handed from the multiply stage to the accumulate stage
  typedef struct packed {
    logic                    valid;
    logic [CMD_W-1:0]        cmd;
    logic                    last;
    logic signed [ACC_W-1:0] product;
    logic signed [VAL_W-1:0] entry;
  } dot_stage_t;

endpackage

`default_nettype wire

### hdl/sdsu_ram.sv
// ----------------------------------------------------------------------------
// sdsu_ram
// Single-port-write, single-port-read dense vector memory, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdsu_ram
  import sdsu_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]       rd_addr,
  output logic      [VAL_W-1:0]               rd_data,
  input  wire logic                           wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]       wr_addr,
  input  wire logic [VAL_W-1:0]               wr_data
);

  logic [VAL_W-1:0] mem [DEPTH];

  // Read returns old data on a same-cycle write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

### hdl/sdsu_pipe.sv
// ----------------------------------------------------------------------------
// sdsu_pipe
// Input register, dense entry fetch with write forwarding, update path and
// dot product multiply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdsu_pipe
  import sdsu_pkg::*;
#(
  parameter int VECTOR_LENGTH = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    adv,
  input  wire logic                    in_valid,
  input  wire logic [CMD_W-1:0]        command,
  input  wire logic [IDX_W-1:0]        elem_index,
  input  wire logic signed [VAL_W-1:0] elem_value,
  input  wire logic signed [VAL_W-1:0] coefficient,
  input  wire logic                    last_element,
  output dot_stage_t                   s3
);

  localparam int AW = $clog2(VECTOR_LENGTH);
  localparam logic [31:0] VEC_LEN = 32'(VECTOR_LENGTH);

  logic accept;
  logic in_ok;
  assign accept = in_valid && adv;
  assign in_ok  = 32'(elem_index) < VEC_LEN;

  // Stage 1 registers
  logic                    s1_valid;
  logic [CMD_W-1:0]        s1_cmd;
  logic [IDX_W-1:0]        s1_idx;
  logic                    s1_ok;
  logic signed [VAL_W-1:0] s1_val;
  logic signed [VAL_W-1:0] s1_coef;
  logic                    s1_last;

  // Stage 2 registers
  logic                    s2_valid;
  logic [CMD_W-1:0]        s2_cmd;
  logic [IDX_W-1:0]        s2_idx;
  logic                    s2_ok;
  logic signed [VAL_W-1:0] s2_val;
  logic                    s2_last;
  logic signed [VAL_W-1:0] s2_entry;
  logic signed [ACC_W-1:0] s2_prod;

  // Last write, kept one beat for the read that missed it
  logic                    w_valid;
  logic [IDX_W-1:0]        w_idx;
  logic [VAL_W-1:0]        w_data;

  logic [VAL_W-1:0]        rd_data;
  logic signed [VAL_W-1:0] entry1;
  logic signed [ACC_W-1:0] upd_prod;
  logic signed [ACC_W-1:0] upd_sum;
  logic signed [VAL_W-1:0] upd_sat;
  logic                    s2_wr;
  logic [VAL_W-1:0]        s2_wdata;
  logic signed [ACC_W-1:0] dot_prod;

  sdsu_ram #(
    .DEPTH (VECTOR_LENGTH)
  ) u_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (AW'(elem_index)),
    .rd_data (rd_data),
    .wr_en   (adv && s2_wr),
    .wr_addr (AW'(s2_idx)),
    .wr_data (s2_wdata)
  );

  // Entry select: newest write wins, out-of-range index reads zero
  always_comb begin
    if (!s1_ok) begin
      entry1 = '0;
    end else if (s2_wr && (s2_idx == s1_idx)) begin
      entry1 = $signed(s2_wdata);
    end else if (w_valid && (w_idx == s1_idx)) begin
      entry1 = $signed(w_data);
    end else begin
      entry1 = $signed(rd_data);
    end
  end

  // Update scale product, full precision
  assign upd_prod = s1_coef * s1_val;

  // Update: floor rescale, add, saturate to 32 bits
  assign upd_sum = $signed({{(ACC_W-VAL_W){s2_entry[VAL_W-1]}}, s2_entry})
                   + (s2_prod >>> FRACTION_BITS);
  always_comb begin
    if (!upd_sum[ACC_W-1] && (|upd_sum[ACC_W-2:VAL_W-1])) begin
      upd_sat = {1'b0, {(VAL_W-1){1'b1}}};
    end else if (upd_sum[ACC_W-1] && !(&upd_sum[ACC_W-2:VAL_W-1])) begin
      upd_sat = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      upd_sat = upd_sum[VAL_W-1:0];
    end
  end

  assign s2_wr    = s2_valid && s2_ok && ((s2_cmd == CMD_LOAD) || (s2_cmd == CMD_UPDATE));
  assign s2_wdata = (s2_cmd == CMD_LOAD) ? s2_val : upd_sat;

  // Dot product term
  assign dot_prod = s2_val * s2_entry;

  // Pipeline registers; only the valid bits are reset
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3.valid <= 1'b0;
      w_valid  <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3.valid <= s2_valid;
      w_valid  <= s2_wr;
    end
    if (accept) begin
      s1_cmd  <= command;
      s1_idx  <= elem_index;
      s1_ok   <= in_ok;
      s1_val  <= elem_value;
      s1_coef <= coefficient;
      s1_last <= last_element;
    end
    if (adv) begin
      s2_cmd     <= s1_cmd;
      s2_idx     <= s1_idx;
      s2_ok      <= s1_ok;
      s2_val     <= s1_val;
      s2_last    <= s1_last;
      s2_entry   <= entry1;
      s2_prod    <= upd_prod;
      s3.cmd     <= s2_cmd;
      s3.last    <= s2_last;
      s3.product <= dot_prod;
      s3.entry   <= s2_entry;
      w_idx      <= s2_idx;
      w_data     <= s2_wdata;
    end
  end

  // A write leaves its data in the forwarding register
  a_fwd_capture: assert property (@(posedge clk) disable iff (rst)
    !rst && adv && s2_wr |=> w_valid && (w_data == $past(s2_wdata)) && (w_idx == $past(s2_idx)))
    else $error("forwarding register missed a write");

  // Stages hold while stalled
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !rst && !adv |=> $stable(s1_valid) && $stable(s2_valid) && $stable(w_valid))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire

### hdl/sdsu_accum.sv
// ----------------------------------------------------------------------------
// sdsu_accum
// Saturating dot accumulator, output rescale and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdsu_accum
  import sdsu_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire dot_stage_t              s3,
  output logic                         adv,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         result_kind,
  output logic signed [RES_W-1:0]      result_value
);

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;
  logic signed [ACC_W-1:0] acc_sum;
  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] dot_shift;
  logic signed [RES_W-1:0] dot_sat;
  logic                    has_result;
  logic                    is_dot;

  assign prod   = $signed(s3.product);
  assign is_dot = s3.valid && (s3.cmd == CMD_DOT);
  assign has_result = s3.valid && ((s3.cmd == CMD_READ) || ((s3.cmd == CMD_DOT) && s3.last));

  // Stall only when a result has nowhere to go
  assign adv = !has_result || !out_valid || out_ready;

  // Saturating 64-bit add
  assign acc_sum = acc + prod;
  always_comb begin
    if (!acc[ACC_W-1] && !prod[ACC_W-1] && acc_sum[ACC_W-1]) begin
      acc_next = {1'b0, {(ACC_W-1){1'b1}}};
    end else if (acc[ACC_W-1] && prod[ACC_W-1] && !acc_sum[ACC_W-1]) begin
      acc_next = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      acc_next = acc_sum;
    end
  end

  // Floor rescale to Q32.16, saturate to 48 bits
  assign dot_shift = acc_next >>> FRACTION_BITS;
  always_comb begin
    if (!dot_shift[ACC_W-1] && (|dot_shift[ACC_W-2:RES_W-1])) begin
      dot_sat = {1'b0, {(RES_W-1){1'b1}}};
    end else if (dot_shift[ACC_W-1] && !(&dot_shift[ACC_W-2:RES_W-1])) begin
      dot_sat = {1'b1, {(RES_W-1){1'b0}}};
    end else begin
      dot_sat = dot_shift[RES_W-1:0];
    end
  end

  // Accumulator, cleared at the end of a run
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (adv && is_dot) begin
      acc <= s3.last ? '0 : acc_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && has_result) begin
      if (s3.cmd == CMD_DOT) begin
        result_kind  <= KIND_DOT;
        result_value <= dot_sat;
      end else begin
        result_kind  <= KIND_READ;
        result_value <= {{(RES_W-VAL_W){s3.entry[VAL_W-1]}}, s3.entry};
      end
    end
  end

  // End of run clears the accumulator
  a_run_clear: assert property (@(posedge clk) disable iff (rst)
    !rst && adv && is_dot && s3.last |=> (acc == '0))
    else $error("accumulator not cleared after last element");

  // A result that leaves the last stage lands in the result register
  a_result_load: assert property (@(posedge clk) disable iff (rst)
    !rst && adv && has_result |=> out_valid)
    else $error("result lost");

  // Read-back beats carry a sign-extended 32-bit entry
  a_read_sext: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == KIND_READ) |->
      (&result_value[RES_W-1:VAL_W-1]) || !(|result_value[RES_W-1:VAL_W-1]))
    else $error("read-back value not sign-extended");

endmodule

`default_nettype wire

### hdl/sparse_dot_and_scatter_update.sv
// ----------------------------------------------------------------------------
// sparse_dot_and_scatter_update
// Dense vector store with sparse dot product runs and scatter updates.
// A result passes the stage 1, 2 and 3 registers, then the result register.
// Throughput: one element per cycle; the input stalls only while a result
// sits in the output register untaken and another result is ready behind it.
// Read-modify-write hazards on the dense store are covered by forwarding.
// Reset clears pipeline valids and the dot accumulator; the store is not
// cleared and has no clearing pass, entries are undefined until loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sparse_dot_and_scatter_update
  import sdsu_pkg::*;
#(
  parameter int VECTOR_LENGTH = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [CMD_W-1:0]        command,
  input  wire logic [IDX_W-1:0]        elem_index,
  input  wire logic signed [VAL_W-1:0] elem_value,
  input  wire logic signed [VAL_W-1:0] coefficient,
  input  wire logic                    last_element,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         result_kind,
  output logic signed [RES_W-1:0]      result_value
);

  logic       adv;
  dot_stage_t s3;

  assign in_ready = adv;

  // Fetch, forward, update and multiply
  sdsu_pipe #(
    .VECTOR_LENGTH (VECTOR_LENGTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_pipe (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (in_valid),
    .command      (command),
    .elem_index   (elem_index),
    .elem_value   (elem_value),
    .coefficient  (coefficient),
    .last_element (last_element),
    .s3           (s3)
  );

  // Accumulate and present results
  sdsu_accum #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_accum (
    .clk          (clk),
    .rst          (rst),
    .s3           (s3),
    .adv          (adv),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .result_value (result_value)
  );

endmodule

`default_nettype wire
